/* rtl/bps_pkg.sv */
// ----------------------------------------------------------------------------
// bps_pkg: shared definitions for the bilinear pixel sampler
// Sizes, fixed-point widths, operation and register codes, and the
// sequencer state and control types used by the sampler and its blend datapath.
// ----------------------------------------------------------------------------
package bps_pkg;

  // Image store geometry.
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

  // Pixel format.
  localparam int CHANNELS = 3;
  localparam int CHAN_W   = 8;
  localparam int PIX_W    = CHANNELS * CHAN_W;

  // Location and blend arithmetic.
  localparam int FRAC_BITS = 8;
  localparam int LOC_W     = 17;
  localparam int INT_W     = LOC_W - 1 - FRAC_BITS;
  localparam int ONE_W     = FRAC_BITS + 1;
  localparam int WEIGHT_W  = 2 * FRAC_BITS + 1;
  localparam int ACC_W     = CHAN_W + 2 * FRAC_BITS;

  // Configuration port.
  localparam int SIZE_W = 8;
  localparam int CFG_W  = 8;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_DONE
  } state_t;

  // Control from the sequencer to the blend datapath.
  typedef struct packed {
    logic clear;
    logic accum;
  } mac_ctl_t;

endpackage

/* rtl/bps_mac.sv */
// ----------------------------------------------------------------------------
// bps_mac: per-channel weighted accumulation
// Multiplies one neighbour pixel by its weight and sums the products of
// all neighbours of a sample; the channel results are the truncated sums.
// ----------------------------------------------------------------------------
module bps_mac (
  input  logic                             clk,
  input  bps_pkg::mac_ctl_t                ctl,
  input  logic [bps_pkg::WEIGHT_W-1:0]     weight,
  input  logic [bps_pkg::PIX_W-1:0]        pixel,
  output logic [bps_pkg::CHANNELS-1:0][bps_pkg::CHAN_W-1:0] chan
);

  localparam int PROD_W = bps_pkg::WEIGHT_W + bps_pkg::CHAN_W;

  logic [bps_pkg::CHANNELS-1:0][bps_pkg::ACC_W-1:0] acc;
  logic [bps_pkg::CHANNELS-1:0][PROD_W-1:0]         prod;

  // One product per channel for the neighbour now on the read port.
  always_comb begin
    for (int c = 0; c < bps_pkg::CHANNELS; c++) begin
      prod[c] = weight * pixel[c*bps_pkg::CHAN_W +: bps_pkg::CHAN_W];
    end
  end

  // The sum of all four weights is exactly one, so the sum fits ACC_W bits.
  always_ff @(posedge clk) begin
    for (int c = 0; c < bps_pkg::CHANNELS; c++) begin
      if (ctl.clear) begin
        acc[c] <= '0;
      end else if (ctl.accum) begin
        acc[c] <= acc[c] + prod[c][bps_pkg::ACC_W-1:0];
      end
    end
  end

  // Drop the fraction bits of the weights.
  always_comb begin
    for (int c = 0; c < bps_pkg::CHANNELS; c++) begin
      chan[c] = acc[c][bps_pkg::ACC_W-1:2*bps_pkg::FRAC_BITS];
    end
  end

endmodule

/* rtl/bilinear_pixel_sampler_unit.sv */
// ----------------------------------------------------------------------------
// bilinear_pixel_sampler_unit: bilinear sampler over a stored RGB image
// Writes pixels into a single-port-read pixel store and returns bilinear
// samples of the four neighbours of a fixed-point location.
//
//   channel   direction  handshake          payload
//   input     in         start / busy       operation, write_*, loc_x, loc_y
//   result    out        out_valid strobe   out_chan0..2
//   config    in         cfg_we             cfg_index, cfg_data
//
// A write gives no result. An interior sample reads its four neighbours
// one per cycle through the store's single read port; a border sample reads
// one pixel. The next item can be taken in the cycle its result shows.
// Reset (rst, synchronous) returns the sequencer to idle and the image size to
// 128 x 128; the store contents are not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module bilinear_pixel_sampler_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               operation,
  input  logic [bps_pkg::COL_W-1:0]          write_col,
  input  logic [bps_pkg::ROW_W-1:0]          write_row,
  input  logic [bps_pkg::CHAN_W-1:0]         write_chan0,
  input  logic [bps_pkg::CHAN_W-1:0]         write_chan1,
  input  logic [bps_pkg::CHAN_W-1:0]         write_chan2,
  input  logic signed [bps_pkg::LOC_W-1:0]   loc_x,
  input  logic signed [bps_pkg::LOC_W-1:0]   loc_y,
  output logic                               out_valid,
  output logic [bps_pkg::CHAN_W-1:0]         out_chan0,
  output logic [bps_pkg::CHAN_W-1:0]         out_chan1,
  output logic [bps_pkg::CHAN_W-1:0]         out_chan2,
  input  logic                               cfg_we,
  input  logic [0:0]                         cfg_index,
  input  logic [bps_pkg::CFG_W-1:0]          cfg_data
);

  bps_pkg::state_t state, state_next;

  logic [bps_pkg::SIZE_W-1:0] image_width;
  logic [bps_pkg::SIZE_W-1:0] image_height;

  logic [bps_pkg::PIX_W-1:0] pixel_store [bps_pkg::DEPTH];
  logic [bps_pkg::PIX_W-1:0] rd_pixel;

  logic                         accept;
  logic                         mem_we;
  logic                         mem_re;
  logic [bps_pkg::ADDR_W-1:0]   raddr;

  logic [bps_pkg::SIZE_W-1:0]   width_eff, height_eff;
  logic [bps_pkg::SIZE_W-1:0]   x_last, y_last;
  logic [bps_pkg::INT_W-1:0]    int_x, int_y;
  logic [bps_pkg::COL_W-1:0]    x0_in;
  logic [bps_pkg::ROW_W-1:0]    y0_in;
  logic [bps_pkg::FRAC_BITS-1:0] fx_in, fy_in;
  logic                         border_in;

  logic [bps_pkg::COL_W-1:0]    x0;
  logic [bps_pkg::ROW_W-1:0]    y0;
  logic [bps_pkg::FRAC_BITS-1:0] fx, fy;
  logic                         border;
  logic [1:0]                   nbr;

  logic [bps_pkg::ONE_W-1:0]    wa, wb;
  logic [2*bps_pkg::ONE_W-1:0]  wprod;
  logic [bps_pkg::WEIGHT_W-1:0] weight;
  logic                         last_read;

  bps_pkg::mac_ctl_t mac_ctl;
  logic [bps_pkg::CHANNELS-1:0][bps_pkg::CHAN_W-1:0] chan;

  assign accept = start && !busy;
  assign mem_we = accept && (operation == bps_pkg::OP_WRITE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bps_pkg::SIZE_W'(bps_pkg::MAX_WIDTH);
      image_height <= bps_pkg::SIZE_W'(bps_pkg::MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        bps_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[bps_pkg::SIZE_W-1:0];
        bps_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[bps_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sizes in effect: zero acts as one, oversize acts as the store size.
  always_comb begin
    width_eff = image_width;
    if (image_width == '0) begin
      width_eff = bps_pkg::SIZE_W'(1);
    end else if (image_width > bps_pkg::SIZE_W'(bps_pkg::MAX_WIDTH)) begin
      width_eff = bps_pkg::SIZE_W'(bps_pkg::MAX_WIDTH);
    end
    height_eff = image_height;
    if (image_height == '0) begin
      height_eff = bps_pkg::SIZE_W'(1);
    end else if (image_height > bps_pkg::SIZE_W'(bps_pkg::MAX_HEIGHT)) begin
      height_eff = bps_pkg::SIZE_W'(bps_pkg::MAX_HEIGHT);
    end
    x_last = width_eff - bps_pkg::SIZE_W'(1);
    y_last = height_eff - bps_pkg::SIZE_W'(1);
  end

  // Split the location into a clamped integer part and a fraction.
  always_comb begin
    int_x = loc_x[bps_pkg::LOC_W-2:bps_pkg::FRAC_BITS];
    int_y = loc_y[bps_pkg::LOC_W-2:bps_pkg::FRAC_BITS];
    if (loc_x[bps_pkg::LOC_W-1]) begin
      x0_in = '0;
      fx_in = '0;
    end else begin
      fx_in = loc_x[bps_pkg::FRAC_BITS-1:0];
      if (int_x > bps_pkg::INT_W'(x_last)) begin
        x0_in = x_last[bps_pkg::COL_W-1:0];
      end else begin
        x0_in = int_x[bps_pkg::COL_W-1:0];
      end
    end
    if (loc_y[bps_pkg::LOC_W-1]) begin
      y0_in = '0;
      fy_in = '0;
    end else begin
      fy_in = loc_y[bps_pkg::FRAC_BITS-1:0];
      if (int_y > bps_pkg::INT_W'(y_last)) begin
        y0_in = y_last[bps_pkg::ROW_W-1:0];
      end else begin
        y0_in = int_y[bps_pkg::ROW_W-1:0];
      end
    end
    border_in = (x0_in == '0) || (y0_in == '0) ||
                (x0_in == x_last[bps_pkg::COL_W-1:0]) ||
                (y0_in == y_last[bps_pkg::ROW_W-1:0]);
  end

  // Capture the sample's location at its transfer.
  always_ff @(posedge clk) begin
    if (accept && (operation == bps_pkg::OP_SAMPLE)) begin
      x0     <= x0_in;
      y0     <= y0_in;
      fx     <= fx_in;
      fy     <= fy_in;
      border <= border_in;
    end
  end

  // Neighbour counter: bit 0 steps right, bit 1 steps down.
  always_ff @(posedge clk) begin
    if (rst) begin
      nbr <= '0;
    end else if (state == bps_pkg::ST_READ) begin
      nbr <= nbr + 2'd1;
    end else begin
      nbr <= '0;
    end
  end

  assign last_read = border || (nbr == 2'd3);

  // Read address of the current neighbour.
  always_comb begin
    raddr = {y0 + bps_pkg::ROW_W'(nbr[1]), x0 + bps_pkg::COL_W'(nbr[0])};
  end

  // Pixel store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pixel_store[{write_row, write_col}] <= {write_chan2, write_chan1, write_chan0};
    end
    if (mem_re) begin
      rd_pixel <= pixel_store[raddr];
    end
  end

  // Weight of the current neighbour, registered in step with its pixel read.
  always_comb begin
    wa = nbr[0] ? bps_pkg::ONE_W'(fx)
                : bps_pkg::ONE_W'(1 << bps_pkg::FRAC_BITS) - bps_pkg::ONE_W'(fx);
    wb = nbr[1] ? bps_pkg::ONE_W'(fy)
                : bps_pkg::ONE_W'(1 << bps_pkg::FRAC_BITS) - bps_pkg::ONE_W'(fy);
    wprod = wa * wb;
  end

  // A border sample keeps weight one on the single pixel read.
  always_ff @(posedge clk) begin
    if (state == bps_pkg::ST_READ) begin
      if (border) begin
        weight <= bps_pkg::WEIGHT_W'(1 << (2 * bps_pkg::FRAC_BITS));
      end else begin
        weight <= wprod[bps_pkg::WEIGHT_W-1:0];
      end
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      bps_pkg::ST_IDLE, bps_pkg::ST_DONE: begin
        if (accept && (operation == bps_pkg::OP_SAMPLE)) begin
          state_next = bps_pkg::ST_READ;
        end else begin
          state_next = bps_pkg::ST_IDLE;
        end
      end
      bps_pkg::ST_READ: begin
        if (last_read) begin
          state_next = bps_pkg::ST_LAST;
        end
      end
      bps_pkg::ST_LAST: state_next = bps_pkg::ST_DONE;
      default:          state_next = bps_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy          = 1'b0;
    mem_re        = 1'b0;
    out_valid     = 1'b0;
    mac_ctl.clear = 1'b0;
    mac_ctl.accum = 1'b0;
    case (state)
      bps_pkg::ST_READ: begin
        busy          = 1'b1;
        mem_re        = 1'b1;
        mac_ctl.clear = (nbr == 2'd0);
        mac_ctl.accum = (nbr != 2'd0);
      end
      bps_pkg::ST_LAST: begin
        busy          = 1'b1;
        mac_ctl.accum = 1'b1;
      end
      bps_pkg::ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  bps_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .weight (weight),
    .pixel  (rd_pixel),
    .chan   (chan)
  );

  assign out_chan0 = chan[0];
  assign out_chan1 = chan[1];
  assign out_chan2 = chan[2];

`ifndef SYNTHESIS
  // A sample transfer always starts a read sequence.
  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == bps_pkg::OP_SAMPLE) |=> busy && mem_re)
    else $error("sample transfer did not start the neighbour reads");

  // A write transfer never produces a result in the next cycle.
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == bps_pkg::OP_WRITE) |=> !out_valid)
    else $error("write transfer produced a result");

  // The final accumulation is followed by exactly one result strobe.
  a_last_then_result: assert property (@(posedge clk) disable iff (rst)
    state == bps_pkg::ST_LAST |=> out_valid ##1 !out_valid || busy)
    else $error("final accumulation not followed by a single result");

  // Border samples read only the top-left pixel.
  a_border_one_read: assert property (@(posedge clk) disable iff (rst)
    mem_re && border |-> nbr == 2'd0)
    else $error("border sample read more than one neighbour");
`endif

endmodule

/* sim/tb_bilinear_pixel_sampler_unit.sv */
// ----------------------------------------------------------------------------
// tb_bilinear_pixel_sampler_unit: self-checking bench for the pixel sampler
// Writes pixels and samples them under a series of image sizes, including
// zero and oversized size values. A local copy of the pixel store and of the
// bilinear blend predicts each sample, and the monitor checks every result
// channel by channel in order. Input transfers come in random bursts and
// gaps, and no location is sampled before its pixels have been written.
// ----------------------------------------------------------------------------
module tb_bilinear_pixel_sampler_unit;
  import bps_pkg::*;

  localparam int NUM_PHASES   = 9;
  localparam int PHASE_ITEMS  = 22;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_REPORTS  = 40;
  localparam int ONE          = 1 << FRAC_BITS;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct {
    op_t                     op;
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
    pixel_t                  px;
    logic signed [LOC_W-1:0] lx;
    logic signed [LOC_W-1:0] ly;
  } pixel_item_t;

  typedef struct {
    pixel_t                  px;
    logic signed [LOC_W-1:0] lx;
    logic signed [LOC_W-1:0] ly;
  } sample_expect_t;

  // Clock, reset and block inputs, all known from time zero.
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    operation = 1'b0;
  logic [COL_W-1:0]        write_col = '0;
  logic [ROW_W-1:0]        write_row = '0;
  logic [CHAN_W-1:0]       write_chan0 = '0;
  logic [CHAN_W-1:0]       write_chan1 = '0;
  logic [CHAN_W-1:0]       write_chan2 = '0;
  logic signed [LOC_W-1:0] loc_x = '0;
  logic signed [LOC_W-1:0] loc_y = '0;
  logic                    cfg_we = 1'b0;
  logic [0:0]              cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    busy;
  logic                    out_valid;
  logic [CHAN_W-1:0]       out_chan0;
  logic [CHAN_W-1:0]       out_chan1;
  logic [CHAN_W-1:0]       out_chan2;

  // Local copy of the image state and size registers.
  pixel_t         pix_mem [DEPTH];
  bit             px_written [DEPTH];
  logic [SIZE_W-1:0] size_w_reg = 8'd128;
  logic [SIZE_W-1:0] size_h_reg = 8'd128;

  pixel_item_t    pending_items [$];
  sample_expect_t expected_samples [$];
  pixel_item_t    cur_item;
  int             burst_left = 0;
  int             gap_left = 0;
  int             mismatch_count = 0;

  bilinear_pixel_sampler_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .write_col   (write_col),
    .write_row   (write_row),
    .write_chan0 (write_chan0),
    .write_chan1 (write_chan1),
    .write_chan2 (write_chan2),
    .loc_x       (loc_x),
    .loc_y       (loc_y),
    .out_valid   (out_valid),
    .out_chan0   (out_chan0),
    .out_chan1   (out_chan1),
    .out_chan2   (out_chan2),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // A zero size acts as one; anything past the store acts as the store size.
  function automatic int eff_size(input logic [SIZE_W-1:0] raw, input int maxv);
    if (raw == 0) return 1;
    if (int'(raw) > maxv) return maxv;
    return int'(raw);
  endfunction

  // Negative locations land on zero; the integer part clamps to the last pixel.
  function automatic void split_coord(input logic signed [LOC_W-1:0] loc,
                                      input int size, output int ip, output int fp);
    if (loc[LOC_W-1]) begin
      ip = 0;
      fp = 0;
    end else begin
      ip = int'(loc[LOC_W-2:FRAC_BITS]);
      fp = int'(loc[FRAC_BITS-1:0]);
      if (ip > size - 1) ip = size - 1;
    end
  endfunction

  function automatic bit on_border(input int x0, input int y0, input int w, input int h);
    return (x0 == 0 || y0 == 0 || x0 == w - 1 || y0 == h - 1);
  endfunction

  function automatic int px_addr(input int col, input int row);
    return row * MAX_WIDTH + col;
  endfunction

  // Apply one accepted item: a write updates the store, a sample queues the
  // blended pixel it must return.
  function automatic void store_or_sample(input pixel_item_t it);
    int             w, h, x0, y0, fx, fy, sum;
    int             wt [4];
    pixel_t         nb [4];
    sample_expect_t e;
    if (it.op == OP_WRITE) begin
      pix_mem[px_addr(int'(it.col), int'(it.row))] = it.px;
    end else begin
      w = eff_size(size_w_reg, MAX_WIDTH);
      h = eff_size(size_h_reg, MAX_HEIGHT);
      split_coord(it.lx, w, x0, fx);
      split_coord(it.ly, h, y0, fy);
      e.lx = it.lx;
      e.ly = it.ly;
      if (on_border(x0, y0, w, h)) begin
        e.px = pix_mem[px_addr(x0, y0)];
      end else begin
        nb[0] = pix_mem[px_addr(x0, y0)];
        nb[1] = pix_mem[px_addr(x0 + 1, y0)];
        nb[2] = pix_mem[px_addr(x0, y0 + 1)];
        nb[3] = pix_mem[px_addr(x0 + 1, y0 + 1)];
        wt[0] = (ONE - fx) * (ONE - fy);
        wt[1] = fx * (ONE - fy);
        wt[2] = (ONE - fx) * fy;
        wt[3] = fx * fy;
        for (int k = 0; k < CHANNELS; k++) begin
          sum = 0;
          for (int n = 0; n < 4; n++) sum += wt[n] * int'(nb[n][CHAN_W*k +: CHAN_W]);
          e.px[CHAN_W*k +: CHAN_W] = CHAN_W'(sum >> (2 * FRAC_BITS));
        end
      end
      expected_samples.push_back(e);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Stimulus building. The written map keeps every sample on written pixels.
  task automatic queue_write(input int col, input int row, input pixel_t px);
    pixel_item_t it;
    it.op  = OP_WRITE;
    it.col = COL_W'(col);
    it.row = ROW_W'(row);
    it.px  = px;
    it.lx  = LOC_W'($urandom);
    it.ly  = LOC_W'($urandom);
    pending_items.push_back(it);
    px_written[px_addr(col, row)] = 1'b1;
  endtask

  task automatic need_pixel(input int col, input int row);
    if (!px_written[px_addr(col, row)]) queue_write(col, row, PIX_W'($urandom));
  endtask

  task automatic queue_sample(input logic signed [LOC_W-1:0] lx,
                              input logic signed [LOC_W-1:0] ly);
    int          w, h, x0, y0, fx, fy;
    pixel_item_t it;
    w = eff_size(size_w_reg, MAX_WIDTH);
    h = eff_size(size_h_reg, MAX_HEIGHT);
    split_coord(lx, w, x0, fx);
    split_coord(ly, h, y0, fy);
    need_pixel(x0, y0);
    if (!on_border(x0, y0, w, h)) begin
      need_pixel(x0 + 1, y0);
      need_pixel(x0, y0 + 1);
      need_pixel(x0 + 1, y0 + 1);
    end
    it.op  = OP_SAMPLE;
    it.col = COL_W'($urandom);
    it.row = ROW_W'($urandom);
    it.px  = PIX_W'($urandom);
    it.lx  = lx;
    it.ly  = ly;
    pending_items.push_back(it);
  endtask

  // Mostly interior locations, some around the borders, some anything at all.
  function automatic logic signed [LOC_W-1:0] rand_coord(input int size);
    int sel, ip;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      ip = (size >= 3) ? $urandom_range(1, size - 2) : $urandom_range(0, size - 1);
      return {1'b0, 8'(ip), 8'($urandom)};
    end else if (sel == 6) begin
      return -LOC_W'($urandom_range(1, 700));
    end else if (sel < 9) begin
      case ($urandom_range(0, 3))
        0: ip = 0;
        1: ip = size - 1;
        2: ip = size;
        default: ip = $urandom_range(size, 255);
      endcase
      if (ip > 255) ip = 255;
      return {1'b0, 8'(ip), 8'($urandom)};
    end
    return LOC_W'($urandom);
  endfunction

  // Register writes happen only with the block idle.
  task automatic write_size_regs(input logic [SIZE_W-1:0] wv, input logic [SIZE_W-1:0] hv);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= wv;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= hv;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_w_reg = wv;
    size_h_reg = hv;
  endtask

  // Wait until every item is taken, every sample returned, and a write that
  // is still in flight has had time to finish.
  task automatic drain_items();
    do @(negedge clk);
    while (pending_items.size() != 0 || start || busy || expected_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Input driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin : item_driver
    bit present;
    if (rst) begin
      start      <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      present = start;
      if (start && !busy) begin
        store_or_sample(cur_item);
        present = 1'b0;
      end
      if (!present) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          operation   <= cur_item.op;
          write_col   <= cur_item.col;
          write_row   <= cur_item.row;
          write_chan0 <= cur_item.px[7:0];
          write_chan1 <= cur_item.px[15:8];
          write_chan2 <= cur_item.px[23:16];
          loc_x       <= cur_item.lx;
          loc_y       <= cur_item.ly;
          present = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
      start <= present;
    end
  end

  // Result monitor: each strobe is checked against the oldest sample.
  always @(posedge clk) begin : result_monitor
    sample_expect_t e;
    pixel_t         got;
    if (!rst && out_valid) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("result with no sample outstanding");
      end else begin
        e   = expected_samples.pop_front();
        got = {out_chan2, out_chan1, out_chan0};
        for (int k = 0; k < CHANNELS; k++) begin
          if (got[CHAN_W*k +: CHAN_W] !== e.px[CHAN_W*k +: CHAN_W])
            report_mismatch($sformatf("out_chan%0d at (%0d,%0d): expected %0d, got %0d",
                                      k, e.lx, e.ly, e.px[CHAN_W*k +: CHAN_W],
                                      got[CHAN_W*k +: CHAN_W]));
        end
      end
    end
  end

  // Test sequence: directed items first, then random items under each size.
  initial begin : test_sequence
    logic [SIZE_W-1:0] phase_w [NUM_PHASES];
    logic [SIZE_W-1:0] phase_h [NUM_PHASES];
    int                w, h;
    phase_w = '{8'd128, 8'd5, 8'd0, 8'd255, 8'd128, 8'd1, 8'd3, 8'd2, 8'd0};
    phase_h = '{8'd128, 8'd7, 8'd0, 8'd129, 8'd1, 8'd128, 8'd3, 8'd2, 8'd0};
    phase_w[7] = SIZE_W'($urandom_range(2, 128));
    phase_h[7] = SIZE_W'($urandom_range(2, 128));
    phase_w[8] = SIZE_W'($urandom_range(0, 255));
    phase_h[8] = SIZE_W'($urandom_range(0, 255));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // The first phase runs on the size the block comes out of reset with.
      if (ph > 0) begin
        drain_items();
        write_size_regs(phase_w[ph], phase_h[ph]);
      end
      @(negedge clk);

      case (ph)
        0: begin
          // Corner pixels, two of them with the extreme channel values.
          queue_write(0, 0, 24'h000000);
          queue_write(MAX_WIDTH - 1, MAX_HEIGHT - 1, 24'hFFFFFF);
          queue_write(MAX_WIDTH - 1, 0, PIX_W'($urandom));
          queue_write(0, MAX_HEIGHT - 1, PIX_W'($urandom));
          // Most negative and largest locations clamp to opposite corners.
          queue_sample(17'h10000, 17'h10000);
          queue_sample(17'h0FFFF, 17'h0FFFF);
          queue_sample(17'h1FFFF, 17'h07FFF);
          queue_sample({1'b0, 8'd127, 8'h40}, {1'b0, 8'd60, 8'h20});
          // Interior with zero fractions, and the deepest interior point.
          queue_sample({1'b0, 8'd1, 8'h00}, {1'b0, 8'd1, 8'h00});
          queue_sample({1'b0, 8'd126, 8'hFF}, {1'b0, 8'd126, 8'hFF});
          // All-white neighbours must blend to no more than full scale.
          queue_write(10, 10, 24'hFFFFFF);
          queue_write(11, 10, 24'hFFFFFF);
          queue_write(10, 11, 24'hFFFFFF);
          queue_write(11, 11, 24'hFFFFFF);
          queue_sample({1'b0, 8'd10, 8'hFF}, {1'b0, 8'd10, 8'hFF});
          queue_sample({1'b0, 8'd10, 8'h01}, {1'b0, 8'd10, 8'h80});
          queue_sample({1'b0, 8'd5, 8'h80}, {1'b0, 8'd9, 8'h80});
        end
        1: begin
          // A pixel outside the 5 x 7 image is still kept in the store.
          queue_write(100, 100, 24'hA5C33C);
          queue_sample({1'b0, 8'd3, 8'h80}, {1'b0, 8'd5, 8'h7F});
          queue_sample({1'b0, 8'd4, 8'h00}, {1'b0, 8'd6, 8'h00});
        end
        2: begin
          // A zero size means one pixel: every sample returns the origin.
          queue_sample({1'b0, 8'd50, 8'h55}, {1'b0, 8'd3, 8'hAA});
        end
        3: begin
          // Oversized registers mean the full store; reach the kept pixel.
          queue_sample({1'b0, 8'd100, 8'h00}, {1'b0, 8'd100, 8'h00});
          queue_sample({1'b0, 8'd99, 8'hC0}, {1'b0, 8'd99, 8'h30});
        end
        default: ;
      endcase

      w = eff_size(size_w_reg, MAX_WIDTH);
      h = eff_size(size_h_reg, MAX_HEIGHT);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0)
          queue_write($urandom_range(0, MAX_WIDTH - 1), $urandom_range(0, MAX_HEIGHT - 1),
                      PIX_W'($urandom));
        else
          queue_sample(rand_coord(w), rand_coord(h));
      end
    end

    drain_items();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin : run_limit
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
rtl/bps_pkg.sv
rtl/bps_mac.sv
rtl/bilinear_pixel_sampler_unit.sv
sim/tb_bilinear_pixel_sampler_unit.sv
